/* src/sle_pkg.sv */
// sle_pkg: shared widths, codes and request/result types of the list engine
package sle_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int FUNC_W    = 3;
  localparam int POS_W     = 11;
  localparam int VAL_W     = 32;
  localparam int ST_W      = 2;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_FIND   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd4;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_BADPOS   = 2'd1;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic [POS_W-1:0]        found_position;
    logic signed [VAL_W-1:0] read_value;
    logic [POS_W-1:0]        length;
  } res_t;

endpackage

/* src/sle_ram.sv */
// sle_ram: generic single-write, single-read RAM with registered read data
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/sequential_list_engine.sv */
// sequential_list_engine: ordered array list with a one-element-per-cycle walk sequencer
//
//   channel   ports                    handshake
//   request   start, busy, in_req      taken when start is high and busy is low
//   result    out_strobe, out_res      valid for one cycle, cannot be held off
//
// clear, refused requests and unknown codes answer in the cycle after the request
// read answers once its single RAM read returns; find reads the elements in order from
// position 1 and answers at the first match, or with not-found after the last element
// insert shifts the tail up and then writes the new value, delete shifts the tail down,
// with the element RAM moving one word per cycle through its read and write ports
// reset (synchronous) empties the list; the RAM contents are not cleared
// busy stays high for the whole walk; a result never waits on the receiver
module sequential_list_engine #(
  parameter int DEPTH = sle_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  sle_pkg::req_t in_req,
  output logic          out_strobe,
  output sle_pkg::res_t out_res
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  localparam int PW = sle_pkg::POS_W;
  localparam int VW = sle_pkg::VAL_W;
  localparam int FW = sle_pkg::FUNC_W;
  localparam int CW = ((LW > PW) ? LW : PW) + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_FILL = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [FW-1:0]        op_r, op_nxt;
  logic signed [VW-1:0] val_r, val_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [AW-1:0]        pend_idx_r, pend_idx_nxt;
  logic [AW-1:0]        fill_idx_r, fill_idx_nxt;
  logic [LW-1:0]        rem_r, rem_nxt;
  logic [LW-1:0]        len_r, len_nxt;
  logic                 pend_r, pend_nxt;
  logic                 strobe_r, strobe_nxt;
  sle_pkg::res_t        res_r, res_nxt;

  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [VW-1:0]        rd_data, wr_data;

  logic [CW-1:0]        pos_c, len_c;
  logic                 ins_ok, seat_ok, full, match;
  logic [LW:0]          found_c;

  sle_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign pos_c   = CW'(in_req.position);
  assign len_c   = CW'(len_r);
  assign ins_ok  = (pos_c != '0) && (pos_c <= len_c + CW'(1));
  assign seat_ok = (pos_c != '0) && (pos_c <= len_c);
  assign full    = (len_c == CW'(DEPTH));
  assign match   = (rd_data == val_r);
  assign found_c = {1'b0, LW'(pend_idx_r)} + (LW + 1)'(1);

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    val_nxt      = val_r;
    idx_nxt      = idx_r;
    pend_idx_nxt = pend_idx_r;
    fill_idx_nxt = fill_idx_r;
    rem_nxt      = rem_r;
    len_nxt      = len_r;
    pend_nxt     = 1'b0;
    strobe_nxt   = 1'b0;
    res_nxt      = '0;
    rd_en        = 1'b0;
    rd_addr      = idx_r;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = rd_data;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt       = in_req.func;
          val_nxt      = in_req.value;
          fill_idx_nxt = AW'(pos_c - CW'(1));
          case (in_req.func)
            sle_pkg::FUNC_CLEAR: begin
              len_nxt    = '0;
              strobe_nxt = 1'b1;
            end
            sle_pkg::FUNC_INSERT: begin
              if (!ins_ok) begin
                res_nxt.status = sle_pkg::ST_BADPOS;
                strobe_nxt     = 1'b1;
              end else if (full) begin
                res_nxt.status = sle_pkg::ST_FULL;
                strobe_nxt     = 1'b1;
              end else begin
                idx_nxt   = AW'(len_c - CW'(1));
                rem_nxt   = LW'(len_c + CW'(1) - pos_c);
                state_nxt = S_WALK;
              end
            end
            sle_pkg::FUNC_DELETE: begin
              if (!seat_ok) begin
                res_nxt.status = sle_pkg::ST_BADPOS;
                strobe_nxt     = 1'b1;
              end else begin
                idx_nxt   = AW'(pos_c);
                rem_nxt   = LW'(len_c - pos_c);
                state_nxt = S_WALK;
              end
            end
            sle_pkg::FUNC_FIND: begin
              if (len_r == '0) begin
                res_nxt.status = sle_pkg::ST_NOTFOUND;
                strobe_nxt     = 1'b1;
              end else begin
                idx_nxt   = '0;
                rem_nxt   = len_r;
                state_nxt = S_WALK;
              end
            end
            sle_pkg::FUNC_READ: begin
              if (!seat_ok) begin
                res_nxt.status = sle_pkg::ST_BADPOS;
                strobe_nxt     = 1'b1;
              end else begin
                idx_nxt   = AW'(pos_c - CW'(1));
                rem_nxt   = LW'(1);
                state_nxt = S_WALK;
              end
            end
            default: begin
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end

      S_WALK: begin
        rd_en        = (rem_r != '0);
        pend_nxt     = rd_en;
        pend_idx_nxt = idx_r;
        if (rd_en) begin
          rem_nxt = rem_r - LW'(1);
          idx_nxt = (op_r == sle_pkg::FUNC_INSERT) ? idx_r - AW'(1) : idx_r + AW'(1);
        end
        case (op_r)
          sle_pkg::FUNC_INSERT: begin
            wr_en   = pend_r;
            wr_addr = pend_idx_r + AW'(1);
            if (rem_r == '0) begin
              state_nxt = S_FILL;
            end
          end
          sle_pkg::FUNC_DELETE: begin
            wr_en   = pend_r;
            wr_addr = pend_idx_r - AW'(1);
            if (rem_r == '0) begin
              len_nxt    = len_r - LW'(1);
              strobe_nxt = 1'b1;
              state_nxt  = S_IDLE;
            end
          end
          sle_pkg::FUNC_FIND: begin
            if (pend_r && match) begin
              res_nxt.found_position = PW'(found_c);
              pend_nxt   = 1'b0;
              rem_nxt    = '0;
              strobe_nxt = 1'b1;
              state_nxt  = S_IDLE;
            end else if (pend_r && (rem_r == '0)) begin
              res_nxt.status = sle_pkg::ST_NOTFOUND;
              pend_nxt   = 1'b0;
              strobe_nxt = 1'b1;
              state_nxt  = S_IDLE;
            end
          end
          sle_pkg::FUNC_READ: begin
            if (pend_r) begin
              res_nxt.read_value = rd_data;
              pend_nxt   = 1'b0;
              strobe_nxt = 1'b1;
              state_nxt  = S_IDLE;
            end
          end
          default: begin
            pend_nxt   = 1'b0;
            strobe_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end
        endcase
      end

      S_FILL: begin
        wr_en      = 1'b1;
        wr_addr    = fill_idx_r;
        wr_data    = val_r;
        len_nxt    = len_r + LW'(1);
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    res_nxt.length = PW'(len_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      len_r    <= '0;
      rem_r    <= '0;
      pend_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      len_r    <= len_nxt;
      rem_r    <= rem_nxt;
      pend_r   <= pend_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    idx_r      <= idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    fill_idx_r <= fill_idx_nxt;
    res_r      <= res_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_res    = res_r;

endmodule

/* src/sle_checker.sv */
// sle_checker: port-level assertions for the list engine, bound to the top level
module sle_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_strobe,
  input sle_pkg::res_t out_res
);

  a_accept_answered: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_strobe))
    else $error("request neither started a walk nor answered");

  a_result_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while busy");

  a_walk_ends_in_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("walk ended without a result");

  a_refused_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_res.status != sle_pkg::ST_OK)) |->
      ((out_res.found_position == '0) && (out_res.read_value == '0)))
    else $error("refused request carries position or value");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_strobe))
    else $error("not idle after reset");

endmodule

bind sequential_list_engine sle_checker u_sle_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_res    (out_res)
);
